// ===== rtl/modt_pkg.sv =====
// Shared types, codes and constants of the masked opcode decode table.
package modt_pkg;

	// Default sizes, handed to the top level as parameter defaults.
	localparam int TABLE_DEPTH_DEF  = 128;
	localparam int HANDLER_BITS_DEF = 8;

	// The home slot comes from the opcode field of a word.
	localparam int OPC_W     = 7;
	localparam int HOME_SPAN = 1 << OPC_W;

	// Fixed match masks of the instruction formats.
	localparam logic [31:0] MASK_OPCODE = 32'h0000_007F;
	localparam logic [31:0] MASK_R      = 32'hFE00_707F;
	localparam logic [31:0] MASK_F3_OPC = (32'h7 << 12) | 32'h7F;
	localparam logic [31:0] MASK_EXACT  = 32'hFFFF_FFFF;

	// Operation codes.
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// Mask selector codes.
	localparam logic [2:0] MSEL_EXPLICIT = 3'd0;
	localparam logic [2:0] MSEL_R        = 3'd1;
	localparam logic [2:0] MSEL_F3_OPC   = 3'd2;
	localparam logic [2:0] MSEL_OPCODE   = 3'd3;
	localparam logic [2:0] MSEL_EXACT    = 3'd4;

	typedef enum logic [1:0] {
		ST_HIT  = 2'd0,
		ST_MISS = 2'd1,
		ST_DONE = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		IDLE,
		CLEAR,
		PROBE
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] entry_key;
		logic [31:0] entry_mask;
		logic [2:0]  mask_select;
		logic [7:0]  handler_id;
		logic [31:0] instr_word;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  handler_out;
		logic [6:0]  slot_out;
	} result_t;

	// Mask that an inserted entry is stored with; unused selectors give zero.
	function automatic logic [31:0] format_mask(input logic [2:0] sel,
	                                            input logic [31:0] explicit_mask);
		logic [31:0] m;
		unique case (sel)
			MSEL_EXPLICIT: m = explicit_mask;
			MSEL_R:        m = MASK_R;
			MSEL_F3_OPC:   m = MASK_F3_OPC;
			MSEL_OPCODE:   m = MASK_OPCODE;
			MSEL_EXACT:    m = MASK_EXACT;
			default:       m = '0;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/masked_opcode_decode_table_core.sv =====
// Top level of the masked opcode decode table: slot memory and probe sequencer.
//
// Usage. A command beat (cmd) is taken at a rising edge with start high and
// busy low. cmd.op selects clear, insert or lookup. Every command gives one
// result beat: result is valid for exactly one cycle while done is high, and
// the receiver cannot hold it off, so it must take every beat it sees.
//
// Timing. Insert and lookup probe one slot per cycle in the slot memory,
// starting at the home slot (low opcode bits modulo the depth) and wrapping.
// The result is registered and shows once the deciding slot is probed; a new
// command can be taken in the cycle the result is shown, so the block takes
// no new command before it is done with the last, and one probe suffices when
// the home slot decides. The single read port of the memory, one address per
// cycle, sets the probe pace. Clear sweeps the memory one slot per cycle to
// its result. An unused op code answers a miss in the next cycle without busy.
//
// Reset. After arst_n is released the block runs the same sweep with busy
// high and gives no result for it. Key, mask and handler words of slots
// never written are not defined, but are never used.
module masked_opcode_decode_table_core #(
	parameter int TABLE_DEPTH  = modt_pkg::TABLE_DEPTH_DEF,
	parameter int HANDLER_BITS = modt_pkg::HANDLER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  modt_pkg::cmd_t    cmd,
	output logic              done,
	output modt_pkg::result_t result
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	// One slot of the table. The valid flag lives in the memory word, so a
	// clear is a write sweep rather than a flip-flop per slot.
	typedef struct packed {
		logic                    valid;
		logic [31:0]             key;
		logic [31:0]             mask;
		logic [HANDLER_BITS-1:0] handler;
	} entry_t;

	// Home slot for every opcode value, built at elaboration.
	typedef logic [modt_pkg::HOME_SPAN-1:0][IDX_W-1:0] home_lut_t;

	function automatic home_lut_t build_home_lut();
		home_lut_t lut;
		for (int i = 0; i < modt_pkg::HOME_SPAN; i++) begin
			lut[i] = IDX_W'(i % TABLE_DEPTH);
		end
		return lut;
	endfunction

	localparam home_lut_t HOME_LUT = build_home_lut();

	modt_pkg::state_t  state_q, state_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic              clr_reply_q, clr_reply_d;
	logic              done_q, done_d;
	modt_pkg::result_t result_q, result_d;
	modt_pkg::cmd_t    cmd_q;
	logic              cmd_load;

	entry_t            mem [TABLE_DEPTH];
	entry_t            rdata_q;
	entry_t            wr_data;
	logic              we;
	logic [IDX_W-1:0]  rd_addr;

	logic [modt_pkg::OPC_W-1:0] home_src;
	logic [IDX_W-1:0]  next_idx;
	logic              last_probe;
	logic              match;

	assign home_src   = (cmd.op == modt_pkg::OP_INSERT) ?
	                    cmd.entry_key[modt_pkg::OPC_W-1:0] :
	                    cmd.instr_word[modt_pkg::OPC_W-1:0];
	assign next_idx   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign last_probe = (cnt_q == LAST_IDX);
	assign match      = (cmd_q.instr_word & rdata_q.mask) == rdata_q.key;

	// Slot memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_q] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// The command is held for the whole probe walk.
	always_ff @(posedge clk) begin
		if (cmd_load) begin
			cmd_q <= cmd;
		end
		result_q <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= modt_pkg::CLEAR;
			idx_q       <= '0;
			cnt_q       <= '0;
			clr_reply_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			cnt_q       <= cnt_d;
			clr_reply_q <= clr_reply_d;
			done_q      <= done_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		cnt_d       = cnt_q;
		clr_reply_d = clr_reply_q;
		done_d      = 1'b0;
		result_d    = '{status: modt_pkg::ST_MISS, handler_out: '0, slot_out: '0};
		cmd_load    = 1'b0;
		rd_addr     = idx_q;
		we          = 1'b0;
		wr_data     = '0;

		unique case (state_q)
			modt_pkg::IDLE: begin
				if (start) begin
					cmd_load = 1'b1;
					if (cmd.op == modt_pkg::OP_CLEAR) begin
						state_d     = modt_pkg::CLEAR;
						idx_d       = '0;
						clr_reply_d = 1'b1;
					end else if (cmd.op == modt_pkg::OP_INSERT ||
					             cmd.op == modt_pkg::OP_LOOKUP) begin
						// Issue the home slot read now; its data is there in
						// the first probe cycle.
						rd_addr = HOME_LUT[home_src];
						idx_d   = HOME_LUT[home_src];
						cnt_d   = '0;
						state_d = modt_pkg::PROBE;
					end else begin
						// Unused operation: a miss, table untouched.
						done_d = 1'b1;
					end
				end
			end

			modt_pkg::CLEAR: begin
				we = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d     = modt_pkg::IDLE;
					done_d      = clr_reply_q;
					clr_reply_d = 1'b0;
					result_d.status = modt_pkg::ST_DONE;
				end else begin
					idx_d = next_idx;
				end
			end

			modt_pkg::PROBE: begin
				// Read ahead of the compare so a slot is probed every cycle.
				rd_addr = next_idx;
				if (cmd_q.op == modt_pkg::OP_INSERT) begin
					priority if (!rdata_q.valid) begin
						we              = 1'b1;
						wr_data.valid   = 1'b1;
						wr_data.key     = cmd_q.entry_key;
						wr_data.mask    = modt_pkg::format_mask(cmd_q.mask_select,
						                                        cmd_q.entry_mask);
						wr_data.handler = HANDLER_BITS'(cmd_q.handler_id);
						state_d         = modt_pkg::IDLE;
						done_d          = 1'b1;
						result_d.status   = modt_pkg::ST_DONE;
						result_d.slot_out = 7'(idx_q);
					end else if (last_probe) begin
						state_d         = modt_pkg::IDLE;
						done_d          = 1'b1;
						result_d.status = modt_pkg::ST_FULL;
					end else begin
						idx_d = next_idx;
						cnt_d = cnt_q + 1'b1;
					end
				end else begin
					priority if (!rdata_q.valid) begin
						state_d = modt_pkg::IDLE;
						done_d  = 1'b1;
					end else if (match) begin
						state_d = modt_pkg::IDLE;
						done_d  = 1'b1;
						result_d.status      = modt_pkg::ST_HIT;
						result_d.handler_out = 8'(rdata_q.handler);
						result_d.slot_out    = 7'(idx_q);
					end else if (last_probe) begin
						// Every slot probed once without a match.
						state_d = modt_pkg::IDLE;
						done_d  = 1'b1;
					end else begin
						idx_d = next_idx;
						cnt_d = cnt_q + 1'b1;
					end
				end
			end

			default: begin
				state_d = modt_pkg::IDLE;
			end
		endcase
	end

	assign busy   = (state_q != modt_pkg::IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/modt_checker.sv =====
// Port-level checks of the masked opcode decode table, bound to the top level.
module modt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input modt_pkg::cmd_t    cmd,
	input logic              done,
	input modt_pkg::result_t result
);

	// Results only appear once the sequencer has gone back to idle.
	a_no_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result beat while busy");

	// A clear, insert or lookup that is taken keeps the block busy.
	a_walk_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.op == modt_pkg::OP_CLEAR ||
		 cmd.op == modt_pkg::OP_INSERT || cmd.op == modt_pkg::OP_LOOKUP)) |=> busy)
		else $error("accepted command did not start a walk");

	// An unused operation answers a miss in the next cycle.
	a_unused_op_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op != modt_pkg::OP_CLEAR &&
		 cmd.op != modt_pkg::OP_INSERT && cmd.op != modt_pkg::OP_LOOKUP)
		|=> (done && result.status == modt_pkg::ST_MISS))
		else $error("unused operation not answered with a miss");

	// Only a hit carries a handler id.
	a_handler_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != modt_pkg::ST_HIT) |-> result.handler_out == '0)
		else $error("handler id on a result that is not a hit");

	// Misses and a full table report no slot.
	a_no_slot_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == modt_pkg::ST_MISS ||
		 result.status == modt_pkg::ST_FULL)) |-> result.slot_out == '0)
		else $error("slot index on a miss or full result");

endmodule

bind masked_opcode_decode_table_core modt_checker u_modt_checker (.*);

// ===== tb/masked_opcode_decode_table_core_test.sv =====
// Self-checking regression of the masked opcode decode table core.
`timescale 1ns / 1ps

module masked_opcode_decode_table_core_test;
	import modt_pkg::*;

	// Sizes follow the defaults that the core is built with here.
	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int HB    = HANDLER_BITS_DEF;

	// Stimulus volume and run limits. The limit covers every item probing the
	// whole table plus the longest sender gap, several times over, on top of
	// the clearing sweep that follows reset.
	localparam int RANDOM_ITEMS = 1950;
	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int DRAIN_CYCLES = DEPTH + 8;

	// Codes that the package does not name: the spare operation and the
	// range of unused mask selectors.
	localparam logic [1:0] OP_SPARE      = 2'd3;
	localparam logic [2:0] MSEL_SPARE_LO = 3'd5;
	localparam logic [2:0] MSEL_SPARE_HI = 3'd7;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	result_t result;

	masked_opcode_decode_table_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// Our own image of the slot memory. Only live slots are ever compared, so
	// the key, mask and handler of empty slots need no reset value.
	bit              slot_live[DEPTH];
	logic [31:0]     slot_key[DEPTH];
	logic [31:0]     slot_mask[DEPTH];
	logic [HB-1:0]   slot_hid[DEPTH];

	// Outcomes predicted at acceptance, oldest first. The core answers every
	// command with exactly one result beat, in command order.
	result_t expected_outcomes[$];

	int errors     = 0;
	int items_sent = 0;
	bit gaps_on    = 1'b1;

	// Opcodes that random traffic draws its home slots from. A small pool
	// forces collisions and long probe chains; the top slots force wrap-around.
	logic [6:0] opcode_pool[8];

	// Mask that an entry is stored with; the unused selectors give no mask at
	// all, so such an entry matches only when its key is zero.
	function automatic logic [31:0] entry_mask_for(input logic [2:0] sel,
	                                               input logic [31:0] explicit_mask);
		logic [31:0] m;
		case (sel)
			MSEL_EXPLICIT: m = explicit_mask;
			MSEL_R:        m = MASK_R;
			MSEL_F3_OPC:   m = MASK_F3_OPC;
			MSEL_OPCODE:   m = MASK_OPCODE;
			MSEL_EXACT:    m = MASK_EXACT;
			default:       m = '0;
		endcase
		return m;
	endfunction

	// Applies one accepted command to the table image and returns the result
	// beat that the core must give for it.
	function automatic result_t decode_table_apply(input cmd_t c);
		result_t r;
		int      idx;
		int      n;
		bit      settled;
		r.status      = ST_MISS;
		r.handler_out = '0;
		r.slot_out    = '0;
		settled       = 1'b0;
		case (c.op)
			OP_CLEAR: begin
				foreach (slot_live[i])
					slot_live[i] = 1'b0;
				r.status = ST_DONE;
			end
			OP_INSERT: begin
				// Linear probe from the home slot for the first empty slot;
				// duplicates are never looked for.
				r.status = ST_FULL;
				idx = (c.entry_key & MASK_OPCODE) % DEPTH;
				for (n = 0; n < DEPTH && !settled; n++) begin
					if (!slot_live[idx]) begin
						slot_live[idx] = 1'b1;
						slot_key[idx]  = c.entry_key;
						slot_mask[idx] = entry_mask_for(c.mask_select, c.entry_mask);
						slot_hid[idx]  = c.handler_id[HB-1:0];
						r.status       = ST_DONE;
						r.slot_out     = 7'(idx);
						settled        = 1'b1;
					end else begin
						idx = (idx + 1) % DEPTH;
					end
				end
			end
			OP_LOOKUP: begin
				// The first live entry that matches under its own mask wins;
				// an empty slot or a full lap ends the search with a miss.
				idx = (c.instr_word & MASK_OPCODE) % DEPTH;
				for (n = 0; n < DEPTH && !settled; n++) begin
					if (!slot_live[idx]) begin
						settled = 1'b1;
					end else if ((c.instr_word & slot_mask[idx]) == slot_key[idx]) begin
						r.status      = ST_HIT;
						r.handler_out = 8'(slot_hid[idx]);
						r.slot_out    = 7'(idx);
						settled       = 1'b1;
					end else begin
						idx = (idx + 1) % DEPTH;
					end
				end
			end
			default: ;  // The spare operation leaves the table alone and misses.
		endcase
		return r;
	endfunction

	// Every field random; callers then set what the operation needs.
	function automatic cmd_t random_fields();
		cmd_t c;
		c.op          = 2'($urandom_range(0, 3));
		c.entry_key   = $urandom();
		c.entry_mask  = $urandom();
		c.mask_select = 3'($urandom_range(0, 7));
		c.handler_id  = 8'($urandom_range(0, 255));
		c.instr_word  = $urandom();
		return c;
	endfunction

	function automatic cmd_t insert_beat(input logic [31:0] key, input logic [31:0] mask,
	                                     input logic [2:0] sel, input logic [7:0] hid);
		cmd_t c;
		c             = random_fields();
		c.op          = OP_INSERT;
		c.entry_key   = key;
		c.entry_mask  = mask;
		c.mask_select = sel;
		c.handler_id  = hid;
		return c;
	endfunction

	function automatic cmd_t lookup_beat(input logic [31:0] word);
		cmd_t c;
		c            = random_fields();
		c.op         = OP_LOOKUP;
		c.instr_word = word;
		return c;
	endfunction

	function automatic cmd_t clear_beat();
		cmd_t c;
		c    = random_fields();
		c.op = OP_CLEAR;
		return c;
	endfunction

	// Sends one command beat. Start stays high from one beat to the next
	// unless a random gap is taken, so it is never lowered and raised in the
	// same time step. Busy is read at the edge, before the core updates it.
	task automatic send_beat(input cmd_t c);
		int gap;
		if (gaps_on && $urandom_range(0, 99) < 31) begin
			start <= 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		cmd   <= c;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		expected_outcomes.push_back(decode_table_apply(c));
		items_sent++;
	endtask

	// Holds the sender off until every predicted beat has come back.
	task automatic wait_drained();
		start <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Some live slot chosen at random, or -1 when the table is empty.
	function automatic int pick_live_slot();
		int first;
		int n;
		int found;
		first = $urandom_range(0, DEPTH - 1);
		found = -1;
		for (n = 0; n < DEPTH && found < 0; n++)
			if (slot_live[(first + n) % DEPTH])
				found = (first + n) % DEPTH;
		return found;
	endfunction

	// A well-formed random insert: the key usually keeps its pool opcode and
	// holds no bits outside its mask, so later lookups can hit it.
	function automatic cmd_t random_insert();
		logic [2:0]  sel;
		logic [31:0] emask;
		logic [31:0] key;
		sel   = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
		        : 3'($urandom_range(MSEL_SPARE_LO, MSEL_SPARE_HI));
		emask = $urandom() | (($urandom_range(0, 3) != 0) ? MASK_OPCODE : 32'h0);
		key   = {25'($urandom() >> 7), opcode_pool[$urandom_range(0, 7)]};
		if ($urandom_range(0, 99) < 80)
			key = key & entry_mask_for(sel, emask);
		return insert_beat(key, emask, sel, 8'($urandom_range(0, 255)));
	endfunction

	// A lookup that mostly aims at a stored entry, with its don't-care bits
	// scrambled; the rest are stray words on the pool opcodes.
	function automatic cmd_t random_lookup();
		int          idx;
		logic [31:0] word;
		idx = pick_live_slot();
		if (idx >= 0 && $urandom_range(0, 99) < 70)
			word = slot_key[idx] | ($urandom() & ~slot_mask[idx]);
		else
			word = {25'($urandom() >> 7), opcode_pool[$urandom_range(0, 7)]};
		return lookup_beat(word);
	endfunction

	// Result checker: every done beat is taken at the edge that ends it and
	// compared with the oldest prediction, field by field.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat: status %0d handler %0d slot %0d",
				         $time, result.status, result.handler_out, result.slot_out);
			end else begin
				want = expected_outcomes.pop_front();
				if (result.status !== want.status) begin
					errors++;
					$display("%0t: status mismatch: expected %0d, got %0d",
					         $time, want.status, result.status);
				end
				if (result.handler_out !== want.handler_out) begin
					errors++;
					$display("%0t: handler mismatch: expected %0d, got %0d",
					         $time, want.handler_out, result.handler_out);
				end
				if (result.slot_out !== want.slot_out) begin
					errors++;
					$display("%0t: slot mismatch: expected %0d, got %0d",
					         $time, want.slot_out, result.slot_out);
				end
			end
		end
	end

	// Each fixed format gets an entry, then lookups hit each one but the R entry,
	// including a word whose first matching entry is not the one with the tightest
	// mask, plus misses on empty home slots. Handler extremes ride along.
	task automatic test_format_masks();
		send_beat(clear_beat());
		send_beat(insert_beat(32'h0000_0033, 32'h0000_707F, MSEL_EXPLICIT, 8'h00));
		send_beat(insert_beat(32'h4000_0033, 32'h0, MSEL_R, 8'hFF));
		send_beat(insert_beat(32'h0000_2003, 32'hFFFF_FFFF, MSEL_F3_OPC, 8'h5A));
		send_beat(insert_beat(32'h0000_006F, 32'h0, MSEL_OPCODE, 8'hA5));
		send_beat(insert_beat(32'hFFFF_FFFF, 32'h0, MSEL_EXACT, 8'h80));
		send_beat(lookup_beat(32'h4000_0033));
		send_beat(lookup_beat(32'h00A5_2083));
		send_beat(lookup_beat(32'hFFFF_F06F));
		send_beat(lookup_beat(32'hFFFF_FFFF));
		send_beat(lookup_beat(32'h0000_0000));
		send_beat(lookup_beat(32'hFFFF_FFFE));
	endtask

	// Entries with unused selectors store no mask, a key with bits outside
	// its mask is kept but never matches, probing wraps from the last slot to
	// slot 0, and the spare operation answers a miss.
	task automatic test_odd_entries();
		send_beat(insert_beat(32'h0000_0000, 32'hFFFF_FFFF, MSEL_SPARE_LO, 8'h11));
		send_beat(insert_beat(32'h0000_0080, 32'h0, MSEL_SPARE_HI, 8'h22));
		send_beat(insert_beat(32'h0000_0000, 32'h0, 3'(MSEL_SPARE_LO + 3'd1), 8'h33));
		send_beat(insert_beat(32'hFFFF_FF7F, 32'h0, MSEL_OPCODE, 8'h44));
		send_beat(insert_beat(32'h0000_0001, 32'hFFFF_FFFF, MSEL_EXPLICIT, 8'hFF));
		send_beat(lookup_beat(32'h1234_5600));
		send_beat(lookup_beat(32'h0000_007F));
		send_beat(lookup_beat(32'h0000_0001));
		begin
			cmd_t c;
			c    = random_fields();
			c.op = OP_SPARE;
			send_beat(c);
		end
		// Let the sender wait out every outstanding result once.
		wait_drained();
	endtask

	// Random traffic in phases. Most phases mix inserts and lookups on a small
	// opcode pool; every fifth fills the table to the brim, tries inserts that
	// must report full and lookups that lap the whole table. One phase runs
	// with no sender gaps at all.
	task automatic test_random_traffic();
		int stop_at;
		int phase;
		int len;
		int k;
		int pick;
		stop_at = items_sent + RANDOM_ITEMS;
		phase   = 0;
		while (items_sent < stop_at) begin
			opcode_pool[0] = 7'h7F;
			opcode_pool[1] = 7'h7E;
			for (k = 2; k < 8; k++)
				opcode_pool[k] = 7'($urandom_range(0, 127));
			gaps_on = (phase != 2);
			if (phase % 5 == 4) begin
				send_beat(clear_beat());
				for (k = 0; k < DEPTH + 3; k++)
					send_beat(random_insert());
				for (k = 0; k < 8; k++)
					send_beat(random_lookup());
				wait_drained();
			end else begin
				if ($urandom_range(0, 1) != 0)
					send_beat(clear_beat());
				len = $urandom_range(30, 120);
				for (k = 0; k < len; k++) begin
					pick = $urandom_range(0, 99);
					if (pick < 46)
						send_beat(random_insert());
					else if (pick < 93)
						send_beat(random_lookup());
					else if (pick < 95)
						send_beat(clear_beat());
					else
						send_beat(random_fields());
				end
			end
			phase++;
		end
		gaps_on = 1'b1;
	endtask

	// Watchdog: a correct run ends long before this.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("masked_opcode_decode_table_core regression: fail");
		$finish;
	end

	// Sequence: one reset, the directed checks, random traffic, then a drain
	// and a quiet stretch long enough for a stray beat from a clear to show.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_format_masks();
		test_odd_entries();
		test_random_traffic();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("masked_opcode_decode_table_core regression: pass");
		else
			$display("masked_opcode_decode_table_core regression: fail");
		$finish;
	end

endmodule

// ===== masked_opcode_decode_table_core.f =====
rtl/modt_pkg.sv
rtl/masked_opcode_decode_table_core.sv
rtl/modt_checker.sv
tb/masked_opcode_decode_table_core_test.sv
